// File: rtl/core/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants for the account storage record decoder.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int HASH_BYTES    = 32;
    localparam int BAL_BYTES     = 32;
    localparam int WORD_BYTES    = 8;
    localparam int NUM_WORDS     = 10;
    localparam int MAX_FIELD_SET = 15;

    localparam logic [3:0] LAST_SLOT = 4'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_FIELDSET = 3'd2,
        ST_HASHLEN  = 3'd3,
        ST_LEADZERO = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    // field indexes in record order
    typedef enum logic [1:0] {
        FLD_NONCE   = 2'd0,
        FLD_BALANCE = 2'd1,
        FLD_INCARN  = 2'd2,
        FLD_HASH    = 2'd3
    } t_field;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       end_of_record;
        logic       empty_record;
    } t_in;

    typedef struct packed {
        logic [3:0]  word_slot;
        logic [63:0] word_value;
        logic [2:0]  status;
        logic        last_word;
    } t_out;

    // finished record handed from the parser to the output stage
    typedef struct packed {
        logic [NUM_WORDS-1:0][63:0] words;
        t_status                    status;
    } t_snap;

endpackage

// File: rtl/core/asd_parser.sv
// ----------------------------------------------------------------------------
// asd_parser
// Byte-wise record parser: field mask, length bytes, big-endian value bytes,
// error latching, and the finished-record snapshot on the record's end.
// ----------------------------------------------------------------------------
module asd_parser
    import asd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_in   i_req,
    output t_snap o_snap
);

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [3:0]     r_mask, n_mask;
    t_field         r_cur, n_cur;
    logic [7:0]     r_left, n_left;
    logic           r_first, n_first;
    logic [63:0]    r_nonce, n_nonce;
    logic [255:0]   r_bal, n_bal;
    logic [63:0]    r_inc, n_inc;
    logic [255:0]   r_hash, n_hash;
    t_status        r_lat, n_lat;
    t_status        r_pend, n_pend;

    logic [7:0]     v_byte;
    logic [2:0]     v_seek;
    logic           v_do_seek;
    logic           v_finish;
    t_status        v_status;
    logic [63:0]    v_nonce;
    logic [255:0]   v_bal;
    logic [63:0]    v_inc;
    logic [255:0]   v_hash;

    // index of the first set mask bit at or above start; 4 when there is none
    function automatic logic [2:0] seek_field(input logic [3:0] mask,
                                              input logic [2:0] start);
        logic [2:0] res;
        res = 3'd4;
        for (int f = 3; f >= 0; f--) begin
            if (3'(f) >= start && mask[f]) begin
                res = 3'(f);
            end
        end
        return res;
    endfunction

    assign v_byte = i_req.record_byte;

    always_comb begin
        n_phase   = r_phase;
        n_mask    = r_mask;
        n_cur     = r_cur;
        n_left    = r_left;
        n_first   = r_first;
        n_nonce   = r_nonce;
        n_bal     = r_bal;
        n_inc     = r_inc;
        n_hash    = r_hash;
        n_lat     = r_lat;
        n_pend    = r_pend;
        v_seek    = 3'd0;
        v_do_seek = 1'b0;
        v_finish  = 1'b0;

        if (r_lat == ST_OK) begin
            unique case (r_phase)
                PH_HEAD: begin
                    if (v_byte > 8'(MAX_FIELD_SET)) begin
                        if (i_req.end_of_record) begin
                            // lone bad head byte reads as too short
                            n_phase = PH_LEN;
                        end else begin
                            n_lat   = ST_FIELDSET;
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_mask    = v_byte[3:0];
                        v_seek    = seek_field(v_byte[3:0], 3'd0);
                        v_do_seek = 1'b1;
                    end
                end
                PH_LEN: begin
                    n_left  = v_byte;
                    n_first = 1'b1;
                    n_pend  = ST_OK;
                    if (r_cur == FLD_HASH) begin
                        if (v_byte != 8'(HASH_BYTES)) begin
                            n_pend = ST_HASHLEN;
                        end
                    end else if (r_cur == FLD_BALANCE) begin
                        if (v_byte > 8'(BAL_BYTES)) begin
                            n_pend = ST_OVERFLOW;
                        end
                    end else if (v_byte > 8'(WORD_BYTES)) begin
                        n_pend = ST_OVERFLOW;
                    end
                    if (v_byte == 8'd0) begin
                        v_finish = 1'b1;
                    end else begin
                        n_phase = PH_VAL;
                    end
                end
                PH_VAL: begin
                    if (r_first && r_pend == ST_OK && v_byte == 8'd0 && r_cur != FLD_HASH) begin
                        n_pend = ST_LEADZERO;
                    end
                    n_first = 1'b0;
                    if (n_pend == ST_OK) begin
                        case (r_cur)
                            FLD_NONCE:   n_nonce = {r_nonce[55:0], v_byte};
                            FLD_BALANCE: n_bal   = {r_bal[247:0], v_byte};
                            FLD_INCARN:  n_inc   = {r_inc[55:0], v_byte};
                            default:     n_hash  = {r_hash[247:0], v_byte};
                        endcase
                    end
                    n_left = r_left - 8'd1;
                    if (n_left == 8'd0) begin
                        v_finish = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (v_finish) begin
            if (n_pend != ST_OK) begin
                n_lat   = n_pend;
                n_phase = PH_DONE;
            end else begin
                v_seek    = seek_field(n_mask, {1'b0, r_cur} + 3'd1);
                v_do_seek = 1'b1;
            end
        end

        if (v_do_seek) begin
            if (v_seek[2]) begin
                n_phase = PH_DONE;
            end else begin
                n_cur   = t_field'(v_seek[1:0]);
                n_phase = PH_LEN;
            end
        end
    end

    // record status and the words as they leave on the last byte
    always_comb begin
        v_nonce = n_nonce;
        v_bal   = n_bal;
        v_inc   = n_inc;
        v_hash  = n_hash;
        if (n_lat != ST_OK) begin
            v_status = n_lat;
        end else if (n_phase != PH_DONE) begin
            v_status = ST_SHORT;
        end else begin
            v_status = ST_OK;
        end
        // a field cut short mid-value reads as zero
        if (v_status != ST_OK && n_lat == ST_OK && n_phase == PH_VAL) begin
            case (n_cur)
                FLD_NONCE:   v_nonce = '0;
                FLD_BALANCE: v_bal   = '0;
                FLD_INCARN:  v_inc   = '0;
                default:     v_hash  = '0;
            endcase
        end
        if (i_req.empty_record) begin
            o_snap.words  = '0;
            o_snap.status = ST_OK;
        end else begin
            o_snap.words[0] = v_nonce;
            o_snap.words[1] = v_bal[255:192];
            o_snap.words[2] = v_bal[191:128];
            o_snap.words[3] = v_bal[127:64];
            o_snap.words[4] = v_bal[63:0];
            o_snap.words[5] = v_inc;
            o_snap.words[6] = v_hash[255:192];
            o_snap.words[7] = v_hash[191:128];
            o_snap.words[8] = v_hash[127:64];
            o_snap.words[9] = v_hash[63:0];
            o_snap.status   = v_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && (i_req.end_of_record || i_req.empty_record))) begin
            r_phase <= PH_HEAD;
            r_mask  <= '0;
            r_cur   <= FLD_NONCE;
            r_left  <= '0;
            r_first <= 1'b1;
            r_nonce <= '0;
            r_bal   <= '0;
            r_inc   <= '0;
            r_hash  <= '0;
            r_lat   <= ST_OK;
            r_pend  <= ST_OK;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_mask  <= n_mask;
            r_cur   <= n_cur;
            r_left  <= n_left;
            r_first <= n_first;
            r_nonce <= n_nonce;
            r_bal   <= n_bal;
            r_inc   <= n_inc;
            r_hash  <= n_hash;
            r_lat   <= n_lat;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: rtl/core/asd_emitter.sv
// ----------------------------------------------------------------------------
// asd_emitter
// Holds one finished record and hands out its ten words, one per cycle while i_stall is low.
// ----------------------------------------------------------------------------
module asd_emitter
    import asd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_snap i_snap,
    input  logic  i_stall,
    output logic  o_valid,
    output t_out  o_rsp,
    output logic  o_free
);

    logic                       r_busy;
    logic [3:0]                 r_slot;
    logic [NUM_WORDS-1:0][63:0] r_words;
    t_status                    r_status;
    logic                       v_take;
    logic                       v_last;

    assign v_last  = (r_slot == LAST_SLOT);
    assign v_take  = r_busy && !i_stall;
    // room for a new record once the last word leaves
    assign o_free  = !r_busy || (v_take && v_last);
    assign o_valid = r_busy;

    assign o_rsp.word_slot  = r_slot;
    assign o_rsp.word_value = r_words[r_slot];
    assign o_rsp.status     = r_status;
    assign o_rsp.last_word  = v_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_slot <= '0;
        end else if (v_take) begin
            if (v_last) begin
                r_busy <= 1'b0;
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_words  <= i_snap.words;
            r_status <= i_snap.status;
        end
    end

endmodule

// File: rtl/core/account_storage_decoder.sv
// ----------------------------------------------------------------------------
// account_storage_decoder
// Parses stored account records one byte per request and emits ten words
// with a status for each record.
// ----------------------------------------------------------------------------
// timing: the first word shows in the cycle after the record's last byte is taken
// throughput: one byte per cycle; while a record's ten words go out,
//   bytes of the next record keep flowing and only its end byte waits
// reset: synchronous active low; clears the parser and drops pending words
module account_storage_decoder
    import asd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_rsp
);

    t_snap w_snap;
    logic  w_free;
    logic  w_take;
    logic  w_ends;

    assign w_ends  = i_req.end_of_record || i_req.empty_record;
    assign o_stall = w_ends && !w_free;
    assign w_take  = i_valid && !o_stall;

    asd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_req   (i_req),
        .o_snap  (w_snap)
    );

    asd_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_take && w_ends),
        .i_snap  (w_snap),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .o_free  (w_free)
    );

endmodule
